// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked checks used in the RTL; each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/rfb_pkg.sv
// ----------------------------------------------------------------------------
// RGB fade brightness driver package
// Word types, opcodes, lane commands and brightness constants.
// ----------------------------------------------------------------------------
package rfb_pkg;

    localparam int CH_W = 8;
    localparam int CNT_W = $clog2(CH_W);
    localparam int NUM_CH = 3;

    localparam logic [CH_W-1:0] BRIGHT_RESET = CH_W'(127);
    localparam logic [CH_W-1:0] BRIGHT_STEP = CH_W'(8);
    localparam logic [CH_W-1:0] BRIGHT_TOP = CH_W'(247);
    localparam logic [CH_W-1:0] BRIGHT_FROM_ZERO = CH_W'(7);

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_FADE     = 3'd1,
        OP_JUMP     = 3'd2,
        OP_BRIGHTER = 3'd3,
        OP_DIMMER   = 3'd4,
        OP_LEVEL    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        LANE_HOLD = 2'd0,
        LANE_LOAD = 2'd1,
        LANE_MUL  = 2'd2,
        LANE_DIV  = 2'd3
    } lane_cmd_t;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] level_in;
    } cmd_word_t;

    typedef struct packed {
        logic [CH_W-1:0] red_drive;
        logic [CH_W-1:0] green_drive;
        logic [CH_W-1:0] blue_drive;
        logic [CH_W-1:0] red_now;
        logic [CH_W-1:0] green_now;
        logic [CH_W-1:0] blue_now;
        logic            fade_last;
    } led_word_t;

endpackage

// File: hdl/rfb_lane.sv
// ----------------------------------------------------------------------------
// RGB fade brightness driver: arithmetic lane
// Bit-serial shift-add multiplier and restoring divider sharing one
// product/remainder shift register, plus a divide-by-255 of the product.
// ----------------------------------------------------------------------------
module rfb_lane (
    input  logic                     clk,
    input  rfb_pkg::lane_cmd_t       cmd,
    input  logic [rfb_pkg::CH_W-1:0] mcand,
    input  logic [rfb_pkg::CH_W-1:0] mplier,
    input  logic [rfb_pkg::CH_W-1:0] divisor,
    output logic [rfb_pkg::CH_W-1:0] quot,
    output logic                     rem_nz,
    output logic [rfb_pkg::CH_W-1:0] scaled
);
    import rfb_pkg::*;

    logic [2*CH_W-1:0] prod_reg;
    logic [2*CH_W-1:0] prod_next;
    logic [CH_W-1:0]   mcand_reg;
    logic [CH_W-1:0]   mcand_next;
    logic [CH_W:0]     mul_sum;
    logic [CH_W:0]     div_trial;
    logic [CH_W:0]     div_diff;
    logic              div_ge;
    logic [CH_W-1:0]   div_rem;
    logic [2*CH_W:0]   scale_sum;

    // one multiplier bit per cycle: add into the high half, shift right
    assign mul_sum = {1'b0, prod_reg[2*CH_W-1:CH_W]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : '0);

    // one quotient bit per cycle: shift in the next dividend bit, trial subtract
    assign div_trial = {prod_reg[2*CH_W-1:CH_W], prod_reg[CH_W-1]};
    assign div_diff  = div_trial - {1'b0, divisor};
    assign div_ge    = (div_trial >= {1'b0, divisor});
    assign div_rem   = div_ge ? div_diff[CH_W-1:0] : div_trial[CH_W-1:0];

    // floor(p / 255) as (p + (p >> 8) + 1) >> 8, exact over the product range
    assign scale_sum = {1'b0, prod_reg} + (2*CH_W+1)'(prod_reg[2*CH_W-1:CH_W])
                     + (2*CH_W+1)'(1);

    assign quot   = prod_reg[CH_W-1:0];
    assign rem_nz = (prod_reg[2*CH_W-1:CH_W] != '0);
    assign scaled = scale_sum[2*CH_W-1:CH_W];

    always_comb
    begin
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        case (cmd)
            LANE_HOLD:
            begin
                prod_next = prod_reg;
            end
            LANE_LOAD:
            begin
                mcand_next = mcand;
                prod_next  = {{CH_W{1'b0}}, mplier};
            end
            LANE_MUL:
            begin
                prod_next = {mul_sum, prod_reg[CH_W-1:1]};
            end
            LANE_DIV:
            begin
                prod_next = {div_rem, prod_reg[CH_W-2:0], div_ge};
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

endmodule

// File: hdl/rgb_fade_brightness_driver.sv
// ----------------------------------------------------------------------------
// RGB fade brightness driver
// Holds the LED color, fade state and brightness; steps linear fades and
// returns scaled drive values through three bit-serial arithmetic lanes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  cmd     | in        | cmd_valid / cmd_stall  | cmd_word (opcode, color, level)
//  led     | out       | led_valid / led_stall  | led_word (drive, now, fade_last)
//
//  Mid-fade tick: fade load, 8 multiply and 8 divide steps, fix-up, scale load,
//  8 brightness multiply steps, then emit loads the one-word output register.
//  Jump, brighter, dimmer and the final fade tick: scale load, 8 brightness
//  multiply steps, emit. Words with no result are taken while staying idle.
//  cmd_stall is high until the result sits in the one-word output register.
//  Reset: colors black, no fade, brightness 127.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_fade_brightness_driver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  rfb_pkg::cmd_word_t cmd_word,
    output logic               led_valid,
    input  logic               led_stall,
    output rfb_pkg::led_word_t led_word
);
    import rfb_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_FADE_LOAD  = 8'b0000_0010,
        ST_FADE_MUL   = 8'b0000_0100,
        ST_FADE_DIV   = 8'b0000_1000,
        ST_FADE_FIX   = 8'b0001_0000,
        ST_SCALE_LOAD = 8'b0010_0000,
        ST_SCALE_MUL  = 8'b0100_0000,
        ST_EMIT       = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CH_W-1:0]  cur_reg [NUM_CH];
    logic [CH_W-1:0]  cur_next [NUM_CH];
    logic [CH_W-1:0]  start_reg [NUM_CH];
    logic [CH_W-1:0]  start_next [NUM_CH];
    logic [CH_W-1:0]  tgt_reg [NUM_CH];
    logic [CH_W-1:0]  tgt_next [NUM_CH];
    logic [CH_W-1:0]  dmag_reg [NUM_CH];
    logic [CH_W-1:0]  dmag_next [NUM_CH];
    logic             dneg_reg [NUM_CH];
    logic             dneg_next [NUM_CH];
    logic [CH_W-1:0]  len_reg, len_next;
    logic [CH_W-1:0]  step_reg, step_next;
    logic             fading_reg, fading_next;
    logic [CH_W-1:0]  bright_reg, bright_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    led_word_t        led_word_reg;
    logic             out_load;

    logic [CH_W-1:0]  new_col [NUM_CH];
    logic [CH_W:0]    col_diff [NUM_CH];
    logic [CH_W:0]    col_diff_neg [NUM_CH];
    logic [CH_W-1:0]  new_mag [NUM_CH];
    logic [CH_W-1:0]  new_len;
    logic [CH_W:0]    step_inc;
    logic             cnt_done;
    logic             quot_ok;
    logic             in_emit;

    lane_cmd_t        lane_cmd;
    logic [CH_W-1:0]  lane_a [NUM_CH];
    logic [CH_W-1:0]  lane_b;
    logic [CH_W-1:0]  lane_quot [NUM_CH];
    logic             lane_rem_nz [NUM_CH];
    logic [CH_W-1:0]  lane_scaled [NUM_CH];

    assign new_col[0] = cmd_word.red_in;
    assign new_col[1] = cmd_word.green_in;
    assign new_col[2] = cmd_word.blue_in;

    assign step_inc = {1'b0, step_reg} + (CH_W+1)'(1);
    assign cnt_done = (cnt_reg == CNT_W'(CH_W-1));

    // signed distance to the new target, kept as sign and magnitude
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            col_diff[c]     = {1'b0, new_col[c]} - {1'b0, cur_reg[c]};
            col_diff_neg[c] = ~col_diff[c] + (CH_W+1)'(1);
            new_mag[c]      = col_diff[c][CH_W] ? col_diff_neg[c][CH_W-1:0]
                                                : col_diff[c][CH_W-1:0];
        end
        new_len = new_mag[0];
        if (new_mag[1] > new_len)
        begin
            new_len = new_mag[1];
        end
        if (new_mag[2] > new_len)
        begin
            new_len = new_mag[2];
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            lane_a[c] = (state_reg == ST_FADE_LOAD) ? dmag_reg[c] : cur_reg[c];
        end
        lane_b = (state_reg == ST_FADE_LOAD) ? step_reg : bright_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        tgt_next       = tgt_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        len_next       = len_reg;
        step_next      = step_reg;
        fading_next    = fading_reg;
        bright_next    = bright_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        lane_cmd       = LANE_HOLD;

        if (out_valid_reg && !led_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_word.opcode)
                        OP_TICK:
                        begin
                            if (fading_reg)
                            begin
                                if (step_inc >= {1'b0, len_reg})
                                begin
                                    cur_next    = tgt_reg;
                                    fading_next = 1'b0;
                                    step_next   = len_reg;
                                    last_next   = 1'b1;
                                    state_next  = ST_SCALE_LOAD;
                                end
                                else
                                begin
                                    step_next  = step_inc[CH_W-1:0];
                                    last_next  = 1'b0;
                                    state_next = ST_FADE_LOAD;
                                end
                            end
                        end
                        OP_FADE:
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                tgt_next[c]   = new_col[c];
                                start_next[c] = cur_reg[c];
                                dmag_next[c]  = new_mag[c];
                                dneg_next[c]  = col_diff[c][CH_W];
                            end
                            len_next    = new_len;
                            step_next   = '0;
                            fading_next = 1'b1;
                        end
                        OP_JUMP:
                        begin
                            tgt_next    = new_col;
                            cur_next    = new_col;
                            fading_next = 1'b0;
                            last_next   = 1'b1;
                            state_next  = ST_SCALE_LOAD;
                        end
                        OP_BRIGHTER:
                        begin
                            last_next = 1'b0;
                            if (bright_reg == '0)
                            begin
                                bright_next = BRIGHT_FROM_ZERO;
                                state_next  = ST_SCALE_LOAD;
                            end
                            else if (bright_reg <= BRIGHT_TOP)
                            begin
                                bright_next = bright_reg + BRIGHT_STEP;
                                state_next  = ST_SCALE_LOAD;
                            end
                        end
                        OP_DIMMER:
                        begin
                            last_next = 1'b0;
                            if (bright_reg >= BRIGHT_STEP)
                            begin
                                bright_next = bright_reg - BRIGHT_STEP;
                                state_next  = ST_SCALE_LOAD;
                            end
                            else if (bright_reg != '0)
                            begin
                                bright_next = '0;
                                state_next  = ST_SCALE_LOAD;
                            end
                        end
                        OP_LEVEL:
                        begin
                            bright_next = cmd_word.level_in;
                        end
                        default:
                        begin
                            // unused opcodes: drop the word
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FADE_LOAD:
            begin
                lane_cmd   = LANE_LOAD;
                cnt_next   = '0;
                state_next = ST_FADE_MUL;
            end
            ST_FADE_MUL:
            begin
                lane_cmd = LANE_MUL;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_FADE_DIV;
                end
            end
            ST_FADE_DIV:
            begin
                lane_cmd = LANE_DIV;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_FADE_FIX;
                end
            end
            ST_FADE_FIX:
            begin
                // negative delta: floor of a negative ratio rounds the magnitude up
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (dneg_reg[c])
                    begin
                        cur_next[c] = start_reg[c] - lane_quot[c]
                                    - CH_W'(lane_rem_nz[c]);
                    end
                    else
                    begin
                        cur_next[c] = start_reg[c] + lane_quot[c];
                    end
                end
                state_next = ST_SCALE_LOAD;
            end
            ST_SCALE_LOAD:
            begin
                lane_cmd   = LANE_LOAD;
                cnt_next   = '0;
                state_next = ST_SCALE_MUL;
            end
            ST_SCALE_MUL:
            begin
                lane_cmd = LANE_MUL;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !led_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_lane
        rfb_lane u_lane (
            .clk     (clk),
            .cmd     (lane_cmd),
            .mcand   (lane_a[g]),
            .mplier  (lane_b),
            .divisor (len_reg),
            .quot    (lane_quot[g]),
            .rem_nz  (lane_rem_nz[g]),
            .scaled  (lane_scaled[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            step_reg      <= '0;
            fading_reg    <= 1'b0;
            bright_reg    <= BRIGHT_RESET;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                cur_reg[c]   <= '0;
                start_reg[c] <= '0;
                tgt_reg[c]   <= '0;
                dmag_reg[c]  <= '0;
                dneg_reg[c]  <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            step_reg      <= step_next;
            fading_reg    <= fading_next;
            bright_reg    <= bright_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            tgt_reg       <= tgt_next;
            dmag_reg      <= dmag_next;
            dneg_reg      <= dneg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            led_word_reg.red_drive   <= lane_scaled[0];
            led_word_reg.green_drive <= lane_scaled[1];
            led_word_reg.blue_drive  <= lane_scaled[2];
            led_word_reg.red_now     <= cur_reg[0];
            led_word_reg.green_now   <= cur_reg[1];
            led_word_reg.blue_now    <= cur_reg[2];
            led_word_reg.fade_last   <= last_reg;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign led_valid = out_valid_reg;
    assign led_word  = led_word_reg;

    assign quot_ok = (lane_quot[0] <= dmag_reg[0]) && (lane_quot[1] <= dmag_reg[1])
                  && (lane_quot[2] <= dmag_reg[2]);
    assign in_emit = (state_reg == ST_EMIT);

    `CHK_ALWAYS(a_step_in_range, step_reg <= len_reg, "fade step beyond fade length")
    `CHK_IMPL(a_quot_bounded, state_reg == ST_FADE_FIX, quot_ok, "fade quotient exceeds delta")
    `CHK_IMPL(a_emit_source, $rose(led_valid), $past(in_emit), "result loaded outside emit")

endmodule

// File: tb/tb_rgb_fade_brightness_driver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB fade brightness driver testbench
// Sends command words in random bursts while the LED side stalls on its own
// pattern. A scoreboard predicts each LED word from the color, fade and
// brightness state and checks every returned word field by field.
// ----------------------------------------------------------------------------
module tb_rgb_fade_brightness_driver;

    import rfb_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int ITEM_TARGET = 450;
    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;

    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_LIGHT    = 2'd1,
        RX_HEAVY    = 2'd2,
        RX_PERIODIC = 2'd3
    } rx_mode_t;

    class led_scoreboard;
        logic [CH_W-1:0] color [NUM_CH];
        logic [CH_W-1:0] fade_from [NUM_CH];
        logic [CH_W-1:0] fade_to [NUM_CH];
        int              fade_delta [NUM_CH];
        int              fade_span;
        int              fade_pos;
        bit              fade_on;
        logic [CH_W-1:0] level;
        led_word_t       led_expected [$];
        int              errors;

        function new();
            for (int c = 0; c < NUM_CH; c++)
            begin
                color[c] = '0;
                fade_from[c] = '0;
                fade_to[c] = '0;
                fade_delta[c] = 0;
            end
            fade_span = 0;
            fade_pos = 0;
            fade_on = 1'b0;
            level = BRIGHT_RESET;
            errors = 0;
        endfunction

        function int pending();
            return led_expected.size();
        endfunction

        function void queue_led(bit last);
            led_word_t e;
            logic [CH_W-1:0] drive [NUM_CH];
            for (int c = 0; c < NUM_CH; c++)
                drive[c] = CH_W'((int'(color[c]) * int'(level)) / 255);
            e.red_drive = drive[0];
            e.green_drive = drive[1];
            e.blue_drive = drive[2];
            e.red_now = color[0];
            e.green_now = color[1];
            e.blue_now = color[2];
            e.fade_last = last;
            led_expected.push_back(e);
        endfunction

        // advance the color state for one accepted command word
        function void predict(cmd_word_t w);
            logic [CH_W-1:0] goal [NUM_CH];
            int next_pos;
            int mag;
            int offset;
            goal[0] = w.red_in;
            goal[1] = w.green_in;
            goal[2] = w.blue_in;
            case (w.opcode)
                OP_TICK:
                begin
                    if (fade_on)
                    begin
                        next_pos = fade_pos + 1;
                        if (next_pos >= fade_span)
                        begin
                            color = fade_to;
                            fade_on = 1'b0;
                            fade_pos = fade_span;
                            queue_led(1'b1);
                        end
                        else
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                mag = (fade_delta[c] < 0 ? -fade_delta[c] : fade_delta[c])
                                      * next_pos;
                                // floor toward minus infinity for falling channels
                                offset = fade_delta[c] >= 0 ? mag / fade_span
                                       : -((mag + fade_span - 1) / fade_span);
                                color[c] = CH_W'(int'(fade_from[c]) + offset);
                            end
                            fade_pos = next_pos;
                            queue_led(1'b0);
                        end
                    end
                end
                OP_FADE:
                begin
                    fade_span = 0;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        fade_to[c] = goal[c];
                        fade_from[c] = color[c];
                        fade_delta[c] = int'(goal[c]) - int'(color[c]);
                        mag = fade_delta[c] < 0 ? -fade_delta[c] : fade_delta[c];
                        if (mag > fade_span)
                            fade_span = mag;
                    end
                    fade_pos = 0;
                    fade_on = 1'b1;
                end
                OP_JUMP:
                begin
                    fade_to = goal;
                    color = goal;
                    fade_on = 1'b0;
                    queue_led(1'b1);
                end
                OP_BRIGHTER:
                begin
                    if (level == '0)
                    begin
                        level = BRIGHT_FROM_ZERO;
                        queue_led(1'b0);
                    end
                    else if (level <= BRIGHT_TOP)
                    begin
                        level = level + BRIGHT_STEP;
                        queue_led(1'b0);
                    end
                end
                OP_DIMMER:
                begin
                    if (level >= BRIGHT_STEP)
                    begin
                        level = level - BRIGHT_STEP;
                        queue_led(1'b0);
                    end
                    else if (level != '0)
                    begin
                        level = '0;
                        queue_led(1'b0);
                    end
                end
                OP_LEVEL:
                    level = w.level_in;
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_led(led_word_t got);
            led_word_t e;
            if (led_expected.size() == 0)
            begin
                report($sformatf("LED word %h with none expected", got));
                return;
            end
            e = led_expected.pop_front();
            if (got.red_drive !== e.red_drive)
                report($sformatf("red_drive %0d, want %0d", got.red_drive, e.red_drive));
            if (got.green_drive !== e.green_drive)
                report($sformatf("green_drive %0d, want %0d", got.green_drive, e.green_drive));
            if (got.blue_drive !== e.blue_drive)
                report($sformatf("blue_drive %0d, want %0d", got.blue_drive, e.blue_drive));
            if (got.red_now !== e.red_now)
                report($sformatf("red_now %0d, want %0d", got.red_now, e.red_now));
            if (got.green_now !== e.green_now)
                report($sformatf("green_now %0d, want %0d", got.green_now, e.green_now));
            if (got.blue_now !== e.blue_now)
                report($sformatf("blue_now %0d, want %0d", got.blue_now, e.blue_now));
            if (got.fade_last !== e.fade_last)
                report($sformatf("fade_last %0b, want %0b", got.fade_last, e.fade_last));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_word_t cmd_word;
    logic      led_valid;
    logic      led_stall = 1'b0;
    led_word_t led_word;

    led_scoreboard sb = new();
    int       idle_cycles = 0;
    int       items_sent = 0;
    int       burst_left = 1;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_age = 0;
    int       rx_phase = 0;

    rgb_fade_brightness_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .led_valid (led_valid),
        .led_stall (led_stall),
        .led_word  (led_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // check results before noting the new word, so a stray result cannot pair with it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (led_valid && !led_stall)
                sb.check_led(led_word);
            if (cmd_valid && !cmd_stall)
                sb.predict(cmd_word);
            if ((led_valid && !led_stall) || (cmd_valid && !cmd_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // LED side: pick a new stall pattern each time the pattern's age count runs out
    always @(negedge clk)
    begin
        if (rx_age == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_age <= $urandom_range(20, 80);
        end
        else
            rx_age <= rx_age - 1;
        rx_phase <= (rx_phase + 1) % 8;
        case (rx_mode)
            RX_OPEN:     led_stall <= 1'b0;
            RX_LIGHT:    led_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY:    led_stall <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: led_stall <= (rx_phase < 5);
            default:     led_stall <= 1'b0;
        endcase
    end

    function automatic cmd_word_t make_word(logic [2:0] op, logic [CH_W-1:0] r,
                                            logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                                            logic [CH_W-1:0] lvl);
        cmd_word_t w;
        w.opcode = op;
        w.red_in = r;
        w.green_in = g;
        w.blue_in = b;
        w.level_in = lvl;
        return w;
    endfunction

    function automatic logic [CH_W-1:0] any_channel();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CH_W-1:0] near_channel(logic [CH_W-1:0] c, int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CH_W'(v);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic push_word(cmd_word_t w);
        int gap;
        items_sent++;
        cmd_word <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic push_op(logic [2:0] op);
        push_word(make_word(op, '0, '0, '0, '0));
    endtask

    task automatic push_level(logic [CH_W-1:0] lvl);
        push_word(make_word(OP_LEVEL, '0, '0, '0, lvl));
    endtask

    initial
    begin
        int pick;
        int spread;
        int count;
        logic [2:0] op;

        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_word = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle tick, unused opcodes, brightness edges, fade corner cases
        push_op(OP_TICK);
        push_word(make_word(OP_SPARE_A, '1, '1, '1, '1));
        push_word(make_word(OP_SPARE_B, '1, '1, '1, '1));
        push_word(make_word(OP_JUMP, 8'd255, 8'd0, 8'd128, 8'd0));
        push_level(8'd255);
        push_op(OP_BRIGHTER);
        push_level(BRIGHT_TOP);
        push_op(OP_BRIGHTER);
        push_op(OP_DIMMER);
        push_level(8'd0);
        push_op(OP_DIMMER);
        push_op(OP_BRIGHTER);
        push_op(OP_DIMMER);
        push_level(8'd5);
        push_op(OP_BRIGHTER);
        push_op(OP_DIMMER);
        push_op(OP_DIMMER);
        push_level(8'd200);
        push_word(make_word(OP_FADE, 8'd255, 8'd0, 8'd128, 8'd0));
        push_op(OP_TICK);
        push_word(make_word(OP_FADE, 8'd254, 8'd1, 8'd128, 8'd0));
        push_op(OP_TICK);
        push_word(make_word(OP_FADE, 8'd0, 8'd255, 8'd0, 8'd0));
        push_op(OP_TICK);
        push_op(OP_TICK);
        // restart mid fade from the present color
        push_word(make_word(OP_FADE, 8'd10, 8'd20, 8'd30, 8'd0));
        push_op(OP_TICK);
        push_word(make_word(OP_JUMP, 8'd0, 8'd0, 8'd0, 8'd0));
        push_op(OP_TICK);

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // fade followed by a run of ticks; short fades may finish, long ones get cut
                if ($urandom_range(0, 9) < 7)
                begin
                    spread = $urandom_range(1, 12);
                    push_word(make_word(OP_FADE, near_channel(sb.color[0], spread),
                                        near_channel(sb.color[1], spread),
                                        near_channel(sb.color[2], spread),
                                        CH_W'($urandom_range(0, 255))));
                end
                else
                    push_word(make_word(OP_FADE, any_channel(), any_channel(),
                                        any_channel(), CH_W'($urandom_range(0, 255))));
                count = $urandom_range(1, 24);
                repeat (count)
                    push_word(make_word(OP_TICK, CH_W'($urandom_range(0, 255)),
                                        CH_W'($urandom_range(0, 255)),
                                        CH_W'($urandom_range(0, 255)),
                                        CH_W'($urandom_range(0, 255))));
            end
            else if (pick < 55)
                push_word(make_word(OP_JUMP, any_channel(), any_channel(), any_channel(),
                                    CH_W'($urandom_range(0, 255))));
            else if (pick < 70)
            begin
                op = $urandom_range(0, 1) ? OP_BRIGHTER : OP_DIMMER;
                count = $urandom_range(1, 8);
                repeat (count)
                    push_op(op);
            end
            else if (pick < 78)
                push_level(any_channel());
            else if (pick < 88)
            begin
                count = $urandom_range(1, 5);
                repeat (count)
                    push_op(OP_TICK);
            end
            else if (pick < 93)
                push_word(make_word($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                                    any_channel(), any_channel(), any_channel(),
                                    any_channel()));
            else
                push_word(make_word(3'($urandom_range(0, 7)), any_channel(), any_channel(),
                                    any_channel(), any_channel()));
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/rfb_pkg.sv
hdl/rfb_lane.sv
hdl/rgb_fade_brightness_driver.sv
tb/tb_rgb_fade_brightness_driver.sv
